[rtl/mcmp_pkg.sv]
// Package with the shared types and constants of the MIDI channel message parser.
package mcmp_pkg;

    localparam int unsigned DataW    = 7;
    localparam int unsigned TickW    = 16;
    localparam int unsigned KindW    = 3;
    localparam int unsigned ChannelW = 4;

    localparam logic [KindW-1:0] KIND_PROGRAM  = 3'd4;
    localparam logic [KindW-1:0] KIND_PRESSURE = 3'd5;
    localparam logic [KindW-1:0] KIND_SYSTEM   = 3'd7;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic [TickW-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [TickW-1:0] TICKS_MAX     = 16'hFFFF;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } event_t;

    typedef struct packed {
        logic [7:0]       status_byte;
        logic [DataW-1:0] first_data;
        logic [DataW-1:0] second_data;
    } message_t;

endpackage

[rtl/mcmp_ifs.sv]
// Valid/ready channel interfaces for events, messages and the configuration write.
interface mcmp_event_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface mcmp_message_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;

    modport source (output valid, output status_byte, output first_data,
                    output second_data, input ready);
    modport sink (input valid, input status_byte, input first_data,
                  input second_data, output ready);
endinterface

interface mcmp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/mcmp_core.sv]
// Running status parser state machine with the idle tick counter.
module mcmp_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  mcmp_pkg::event_t                    item,
    input  logic [mcmp_pkg::TickW-1:0]          timeout_ticks,
    output logic                                res_valid,
    output mcmp_pkg::message_t                  res
);
    import mcmp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [KindW-1:0]    kind_reg, kind_next;
    logic [ChannelW-1:0] channel_reg, channel_next;
    logic [DataW-1:0]    first_reg, first_next;
    logic [DataW-1:0]    second_reg, second_next;
    logic [TickW-1:0]    ticks_reg, ticks_next;
    logic                one_byte_kind;
    logic                emit;

    assign one_byte_kind = (kind_reg == KIND_PROGRAM) || (kind_reg == KIND_PRESSURE);

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        channel_next = channel_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        ticks_next   = ticks_reg;
        emit         = 1'b0;
        if (item.action == ACTION_TICK)
        begin
            if (ticks_reg != TICKS_MAX)
            begin
                ticks_next = ticks_reg + 1'b1;
            end
            if (ticks_next > timeout_ticks)
            begin
                phase_next   = ST_IDLE;
                channel_next = '0;
                first_next   = '0;
                second_next  = '0;
            end
        end
        else
        begin
            ticks_next = '0;
            if (item.rx_byte[7])
            begin
                if (item.rx_byte[6:4] == KIND_SYSTEM)
                begin
                    phase_next   = ST_IDLE;
                    channel_next = '0;
                    first_next   = '0;
                    second_next  = '0;
                end
                else
                begin
                    phase_next   = ST_FIRST;
                    kind_next    = item.rx_byte[6:4];
                    channel_next = item.rx_byte[3:0];
                end
            end
            else
            begin
                unique case (phase_reg)
                    ST_FIRST:
                    begin
                        first_next = item.rx_byte[6:0];
                        if (one_byte_kind)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            phase_next = ST_SECOND;
                        end
                    end
                    ST_SECOND:
                    begin
                        second_next = item.rx_byte[6:0];
                        emit        = 1'b1;
                        phase_next  = ST_FIRST;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    assign res_valid       = advance && emit;
    assign res.status_byte = {1'b1, kind_reg, channel_reg};
    assign res.first_data  = first_next;
    assign res.second_data = second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ST_IDLE;
            kind_reg    <= '0;
            channel_reg <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            ticks_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            channel_reg <= channel_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            ticks_reg   <= ticks_next;
        end
    end

    a_system_byte_idles: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.action == ACTION_BYTE && item.rx_byte[7:4] == 4'hF
        |=> phase_reg == ST_IDLE && channel_reg == '0)
        else $error("System byte did not return the parser to idle.");

    a_second_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ST_SECOND |-> !one_byte_kind)
        else $error("One-byte kind is waiting for a second data byte.");

    a_byte_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.action == ACTION_BYTE |=> ticks_reg == '0)
        else $error("Received byte did not clear the idle tick count.");

    a_emit_only_armed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> phase_reg != ST_IDLE && !item.rx_byte[7])
        else $error("Message emitted while the parser was not armed.");

endmodule

[rtl/midi_channel_message_parser_unit.sv]
// Top level of the MIDI channel message parser with input stage and output queue.
//
// The events channel carries one transfer per received MIDI byte (action 0) or
// per millisecond tick (action 1). The messages channel carries one transfer
// per complete channel message: the rebuilt status byte and the two data bytes.
// The cfg channel writes the 16-bit idle timeout in ticks and is always ready;
// the user must write it only while no event is in flight; this is not enforced.
//
// An event is registered in the input stage on acceptance and processed from
// there once the output queue has room; the message that its data byte
// completes is written into the output queue and offered on the messages
// channel from there. One event is taken every cycle while the queue has room.
// Results go to a two-entry output queue; the events channel stays ready
// while the queue has room or the input stage is empty, so a stalled receiver
// holds back input only once two messages are waiting and an event is held
// in the input stage.
//
// Reset clears the parser to idle, the tick count to zero, the timeout to
// 100 ticks and empties the input stage and the output queue.
module midi_channel_message_parser_unit (
    input logic             clk,
    input logic             rst_n,
    mcmp_event_if.sink      events,
    mcmp_message_if.source  messages,
    mcmp_cfg_if.sink        cfg
);
    import mcmp_pkg::*;

    logic             in_valid_reg;
    event_t           in_item_reg;
    logic [TickW-1:0] timeout_reg;
    message_t         queue_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             queue_full;
    logic             advance;
    logic             res_valid;
    message_t         res;
    logic             push;
    logic             pop;

    assign queue_full   = count_reg[1];
    assign advance      = in_valid_reg && !queue_full;
    assign events.ready = !in_valid_reg || !queue_full;
    assign cfg.ready    = 1'b1;
    assign push         = res_valid;
    assign pop          = messages.valid && messages.ready;

    assign messages.valid       = count_reg != 2'd0;
    assign messages.status_byte = queue_reg[rd_ptr_reg].status_byte;
    assign messages.first_data  = queue_reg[rd_ptr_reg].first_data;
    assign messages.second_data = queue_reg[rd_ptr_reg].second_data;

    mcmp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (in_item_reg),
        .timeout_ticks (timeout_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
        end
        else
        begin
            if (events.valid && events.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.data;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            in_item_reg.action  <= events.action;
            in_item_reg.rx_byte <= events.rx_byte;
        end
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= res;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("Output queue count is out of range.");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("Message pushed into a full output queue.");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("Queue pointers disagree with the count.");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && queue_full |=> in_valid_reg && $stable(in_item_reg))
        else $error("Pending event lost while the output queue was full.");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the MIDI channel message parser unit.
`timescale 1ns / 100ps

module testbench;
    import mcmp_pkg::*;

    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_FIRST_BASE  = 4'd1;
    localparam logic [3:0] ST_SECOND_BASE = 4'd8;

    logic clk;
    logic rst_n;

    mcmp_event_if   ev_if ();
    mcmp_message_if msg_if ();
    mcmp_cfg_if     cfg_if ();

    midi_channel_message_parser_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .events   (ev_if),
        .messages (msg_if),
        .cfg      (cfg_if)
    );

    // Shadow copy of the parser state, updated on every accepted event.
    logic [3:0]       parse_state;
    logic [3:0]       midi_channel;
    logic [DataW-1:0] held_first;
    logic [DataW-1:0] held_second;
    logic [TickW-1:0] idle_ticks;
    logic [TickW-1:0] timeout_ticks;

    message_t expected_msgs[$];
    int unsigned mismatch_count;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned hold_cycles_left;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic bit kind_has_two(input logic [KindW-1:0] kind);
        return kind != KIND_PROGRAM && kind != KIND_PRESSURE;
    endfunction

    function automatic void clear_parser();
        parse_state  = ST_IDLE;
        midi_channel = '0;
        held_first   = '0;
        held_second  = '0;
    endfunction

    function automatic void push_message(input logic [KindW-1:0] kind);
        message_t msg;
        msg.status_byte = {1'b1, kind, midi_channel};
        msg.first_data  = held_first;
        msg.second_data = held_second;
        expected_msgs.push_back(msg);
    endfunction

    function automatic void parse_midi_event(input logic action, input logic [7:0] rx_byte);
        logic [KindW-1:0] kind;
        if (action == ACTION_TICK)
        begin
            if (idle_ticks != TICKS_MAX)
                idle_ticks = idle_ticks + 1'b1;
            if (idle_ticks > timeout_ticks)
                clear_parser();
            return;
        end
        idle_ticks = '0;
        if (rx_byte[7])
        begin
            kind = rx_byte[6:4];
            if (kind == KIND_SYSTEM)
                clear_parser();
            else
            begin
                midi_channel = rx_byte[3:0];
                parse_state  = ST_FIRST_BASE + kind;
            end
        end
        else if (parse_state >= ST_FIRST_BASE && parse_state < ST_FIRST_BASE + 4'd7)
        begin
            kind = KindW'(parse_state - ST_FIRST_BASE);
            held_first = rx_byte[6:0];
            if (kind_has_two(kind))
                parse_state = ST_SECOND_BASE + kind;
            else
                push_message(kind);
        end
        else if (parse_state >= ST_SECOND_BASE && parse_state < ST_SECOND_BASE + 4'd7)
        begin
            kind = KindW'(parse_state - ST_SECOND_BASE);
            if (kind_has_two(kind))
            begin
                held_second = rx_byte[6:0];
                push_message(kind);
                parse_state = ST_FIRST_BASE + kind;
            end
        end
    endfunction

    // Receiver side: random stalls, or a forced hold-off while hold_cycles_left runs down.
    always @(negedge clk)
    begin
        if (hold_cycles_left > 0)
        begin
            msg_if.ready <= 1'b0;
            hold_cycles_left = hold_cycles_left - 1;
        end
        else
            msg_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        message_t got;
        message_t want;
        if (rst_n && msg_if.valid && msg_if.ready)
        begin
            got.status_byte = msg_if.status_byte;
            got.first_data  = msg_if.first_data;
            got.second_data = msg_if.second_data;
            if (expected_msgs.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                $display("%0t: unexpected message %02h %02h %02h", $time,
                         got.status_byte, got.first_data, got.second_data);
            end
            else
            begin
                want = expected_msgs.pop_front();
                if (got != want)
                begin
                    mismatch_count = mismatch_count + 1;
                    $display("%0t: message mismatch, expected %02h %02h %02h, got %02h %02h %02h",
                             $time, want.status_byte, want.first_data, want.second_data,
                             got.status_byte, got.first_data, got.second_data);
                end
            end
        end
    end

    task automatic send_event(input logic action, input logic [7:0] rx_byte);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            ev_if.valid <= 1'b0;
            @(negedge clk);
        end
        ev_if.valid   <= 1'b1;
        ev_if.action  <= action;
        ev_if.rx_byte <= rx_byte;
        @(posedge clk);
        while (!ev_if.ready)
            @(posedge clk);
        parse_midi_event(action, rx_byte);
    endtask

    task automatic send_byte(input logic [7:0] rx_byte);
        send_event(ACTION_BYTE, rx_byte);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count)
            send_event(ACTION_TICK, 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        ev_if.valid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TickW-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        timeout_ticks = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_channel_messages();
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h9F);
        send_byte(8'h7F);
        send_byte(8'h7F);
        send_byte(8'hA3);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'hB7);
        send_byte(8'h40);
        send_byte(8'h7F);
        send_byte(8'hC5);
        send_byte(8'h7F);
        send_byte(8'h33);
        send_byte(8'hDA);
        send_byte(8'h05);
        send_byte(8'hE0);
        send_byte(8'h00);
        send_byte(8'h40);
    endtask

    task automatic test_system_bytes();
        send_byte(8'h95);
        send_byte(8'h30);
        send_byte(8'hF8);
        send_byte(8'h31);
        send_byte(8'h90);
        send_byte(8'hC1);
        send_byte(8'h10);
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'hF0);
    endtask

    task automatic test_timeout();
        send_byte(8'h92);
        send_ticks(TIMEOUT_RESET);
        send_byte(8'h21);
        send_byte(8'h22);
        send_ticks(TIMEOUT_RESET + 1);
        send_byte(8'h23);
        send_byte(8'h24);
        write_timeout(16'd1);
        send_byte(8'hE4);
        send_ticks(1);
        send_byte(8'h05);
        send_ticks(2);
        send_byte(8'h06);
        send_byte(8'h07);
    endtask

    task automatic test_tick_saturation();
        write_timeout(TICKS_MAX);
        send_byte(8'hB2);
        send_byte(8'h10);
        send_ticks(32'(TIMEOUT_RESET) + 50);
        send_byte(8'h20);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles_left = 300;
        send_byte(8'h9C);
        repeat (30)
        begin
            send_byte(8'($urandom_range(127)));
            send_byte(8'($urandom_range(127)));
        end
    endtask

    task automatic send_random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned pick;
        int unsigned reps;
        logic [KindW-1:0] kind;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                kind = KindW'($urandom_range(6));
                send_byte({1'b1, kind, 4'($urandom_range(15))});
                reps = $urandom_range(1, 4);
                sent = sent + 1;
                repeat (reps)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_ticks(1);
                        sent = sent + 1;
                    end
                    send_byte(8'($urandom_range(127)));
                    sent = sent + 1;
                    if (kind_has_two(kind))
                    begin
                        send_byte(8'($urandom_range(127)));
                        sent = sent + 1;
                    end
                end
            end
            else if (pick < 80)
            begin
                reps = $urandom_range(1, 8);
                send_ticks(reps);
                sent = sent + reps;
            end
            else if (pick < 88)
            begin
                send_byte(8'($urandom_range(8'hF0, 8'hFF)));
                sent = sent + 1;
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
                sent = sent + 1;
            end
        end
    endtask

    task automatic test_random();
        write_timeout(16'd3);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_random_traffic(70);
        write_timeout(16'd1);
        sender_idle_pct    = 46;
        receiver_stall_pct = 0;
        send_random_traffic(70);
        write_timeout(TICKS_MAX);
        sender_idle_pct    = 0;
        receiver_stall_pct = 46;
        send_random_traffic(70);
        write_timeout(16'($urandom_range(2, 20)));
        sender_idle_pct    = 34;
        receiver_stall_pct = 34;
        send_random_traffic(70);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        ev_if.valid    = 1'b0;
        ev_if.action   = ACTION_BYTE;
        ev_if.rx_byte  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        mismatch_count     = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles_left   = 0;
        timeout_ticks = TIMEOUT_RESET;
        idle_ticks    = '0;
        clear_parser();
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_channel_messages();
        test_system_bytes();
        test_timeout();
        test_tick_saturation();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0 && expected_msgs.size() == 0)
            $display("tb: success");
        else
        begin
            if (expected_msgs.size() != 0)
                $display("%0t: %0d expected messages never arrived", $time,
                         expected_msgs.size());
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: run timed out with %0d messages outstanding", $time,
                 expected_msgs.size());
        $display("tb: failure");
        $finish;
    end

endmodule
